/* src/au2x_pkg.sv */
`default_nettype none

package au2x_pkg;

    // Default width of one audio sample
    localparam int SAMPLE_BITS_DEF = 24;

    // Stored past samples and the window they form with the new sample
    localparam int HISTORY_DEPTH = 5;
    localparam int WIN_LEN       = HISTORY_DEPTH + 1;

    // Midpoint filter weights over 2**ROUND_SHIFT
    localparam int W_OUTER    = 3;
    localparam int W_INNER    = 25;   // applied with negative sign
    localparam int W_CENTER   = 150;
    localparam int ROUND_SHIFT = 8;
    localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

    // Headroom of the filter accumulator above the sample width
    localparam int ACC_GUARD = 10;

    // Mode register codes
    localparam logic MODE_LINEAR   = 1'b0;
    localparam logic MODE_LAGRANGE = 1'b1;
    localparam logic MODE_RESET    = MODE_LAGRANGE;

    typedef enum logic [1:0] {
        OUT_EMPTY,
        OUT_FIRST,
        OUT_SECOND
    } t_out_state;

endpackage

`default_nettype wire

/* src/au2x_window.sv */
`default_nettype none

module au2x_window #(
    parameter int SAMPLE_BITS = au2x_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_valid,
    input  wire logic [SAMPLE_BITS-1:0]                        i_sample,
    output logic                                               o_stall,
    input  wire logic                                          i_take,
    output logic                                               o_vld,
    output logic [au2x_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0]      o_win
);
    import au2x_pkg::*;

    // r_win[0] is the newest sample, r_win[k] the sample k places back
    logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] r_win;
    logic                                r_vld;
    logic                                accept;

    assign o_stall = r_vld && !i_take;
    assign accept  = i_valid && !o_stall;
    assign o_vld   = r_vld;
    assign o_win   = r_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_win <= '0;
        end else begin
            if (accept) begin
                r_vld <= 1'b1;
                r_win <= {r_win[WIN_LEN-2:0], i_sample};
            end else if (i_take) begin
                r_vld <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_accept_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_vld)
        else $error("accepted beat not held in window stage");

    a_wait_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && !i_take) |=> (r_vld && $stable(r_win)))
        else $error("window changed while its item waited");
`endif

endmodule

`default_nettype wire

/* src/au2x_interp.sv */
`default_nettype none

module au2x_interp #(
    parameter int SAMPLE_BITS = au2x_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                          i_mode,
    input  wire logic [au2x_pkg::WIN_LEN-1:0][SAMPLE_BITS-1:0] i_win,
    output logic [SAMPLE_BITS-1:0]                             o_first,
    output logic [SAMPLE_BITS-1:0]                             o_second
);
    import au2x_pkg::*;

    localparam int ACC_W = SAMPLE_BITS + ACC_GUARD;
    localparam int RES_W = ACC_W - ROUND_SHIFT;

    localparam logic signed [RES_W-1:0] SAT_MAX =
        {{(RES_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [RES_W-1:0] SAT_MIN =
        {{(RES_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

    logic signed [ACC_W-1:0] x [WIN_LEN];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] lin_sum;
    logic signed [RES_W-1:0] res;
    logic [SAMPLE_BITS-1:0]  first_lag;
    logic [SAMPLE_BITS-1:0]  first_lin;

    always_comb begin
        for (int k = 0; k < WIN_LEN; k++) begin
            x[k] = ACC_W'(signed'(i_win[k]));
        end
    end

    // Symmetric taps: pair the samples before weighting
    assign acc = ACC_W'(W_CENTER) * (x[2] + x[3])
               - ACC_W'(W_INNER)  * (x[1] + x[4])
               + ACC_W'(W_OUTER)  * (x[0] + x[5])
               + ACC_W'(ROUND_BIAS);

    assign res = acc[ACC_W-1:ROUND_SHIFT];

    always_comb begin
        if (res > SAT_MAX) begin
            first_lag = SAT_MAX[SAMPLE_BITS-1:0];
        end else if (res < SAT_MIN) begin
            first_lag = SAT_MIN[SAMPLE_BITS-1:0];
        end else begin
            first_lag = res[SAMPLE_BITS-1:0];
        end
    end

    // Mean of the two newest, rounded half up
    assign lin_sum   = x[0] + x[1] + ACC_W'(1);
    assign first_lin = lin_sum[SAMPLE_BITS:1];

    always_comb begin
        if (i_mode == MODE_LAGRANGE) begin
            o_first  = first_lag;
            o_second = i_win[2];
        end else begin
            o_first  = first_lin;
            o_second = i_win[0];
        end
    end

endmodule

`default_nettype wire

/* src/au2x_out.sv */
`default_nettype none

module au2x_out #(
    parameter int SAMPLE_BITS = au2x_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load_vld,
    input  wire logic [SAMPLE_BITS-1:0] i_first,
    input  wire logic [SAMPLE_BITS-1:0] i_second,
    output logic                        o_load,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_sample,
    output logic                        o_last
);
    import au2x_pkg::*;

    t_out_state             r_state;
    t_out_state             n_state;
    logic [SAMPLE_BITS-1:0] r_first;
    logic [SAMPLE_BITS-1:0] r_second;
    logic                   beat_done;

    assign beat_done = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        if (o_load) begin
            n_state = OUT_FIRST;
        end else begin
            unique case (r_state)
                OUT_EMPTY:  n_state = OUT_EMPTY;
                OUT_FIRST:  if (beat_done) n_state = OUT_SECOND;
                OUT_SECOND: if (beat_done) n_state = OUT_EMPTY;
                default:    n_state = OUT_EMPTY;
            endcase
        end
    end

    always_comb begin
        unique case (r_state)
            OUT_EMPTY: begin
                o_valid  = 1'b0;
                o_last   = 1'b0;
                o_sample = r_first;
                o_load   = i_load_vld;
            end
            OUT_FIRST: begin
                o_valid  = 1'b1;
                o_last   = 1'b0;
                o_sample = r_first;
                o_load   = 1'b0;
            end
            OUT_SECOND: begin
                o_valid  = 1'b1;
                o_last   = 1'b1;
                o_sample = r_second;
                // refill as the last beat leaves
                o_load   = i_load_vld && !i_stall;
            end
            default: begin
                o_valid  = 1'b0;
                o_last   = 1'b0;
                o_sample = r_first;
                o_load   = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= OUT_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_first  <= i_first;
            r_second <= i_second;
        end
    end

`ifndef SYNTHESIS
    a_first_then_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_last) |=> (o_valid && o_last))
        else $error("first beat not followed by last beat");

    a_drain_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last && !i_stall && !i_load_vld) |=> !o_valid)
        else $error("output valid with no item loaded");
`endif

endmodule

`default_nettype wire

/* src/audio_2x_upsampler_unit.sv */
`default_nettype none

// Two-times audio upsampler.
// Input channel: i_valid / o_stall carry one signed sample per beat on
// i_sample_in. Output channel: o_valid / i_stall carry two beats per input
// sample on o_sample_out; o_last marks the second beat of each pair.
// Mode (i_cfg_we / i_cfg_wdata): 0 gives the rounded mean of the previous
// and new sample then the new sample; 1 gives the six-point midpoint filter
// over the last six samples then the sample two places back, saturated.
// The first beat of a pair is offered once its input sample has passed the
// window register and been loaded into the output pair register; the second
// beat is offered once the first beat has left.
// Each input sample gives two beats on the single output port, which emits
// one output beat per cycle while the receiver does not stall.
// The window stage takes a new sample while the output pair register still
// drains, so the output runs without gaps.
// Reset clears the sample history to zero, sets mode to 1 and empties both
// stages. When the receiver stalls, the current beat holds and the input
// backs up once the window stage holds a sample waiting to load.
module audio_2x_upsampler_unit #(
    parameter int SAMPLE_BITS = au2x_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_sample_in,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic [SAMPLE_BITS-1:0]      o_sample_out,
    output logic                        o_last
);
    import au2x_pkg::*;

    logic                                r_mode;
    logic                                win_vld;
    logic                                load;
    logic [WIN_LEN-1:0][SAMPLE_BITS-1:0] win;
    logic [SAMPLE_BITS-1:0]              first;
    logic [SAMPLE_BITS-1:0]              second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    au2x_window #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sample (i_sample_in),
        .o_stall  (o_stall),
        .i_take   (load),
        .o_vld    (win_vld),
        .o_win    (win)
    );

    au2x_interp #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_interp (
        .i_mode   (r_mode),
        .i_win    (win),
        .o_first  (first),
        .o_second (second)
    );

    au2x_out #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load_vld (win_vld),
        .i_first    (first),
        .i_second   (second),
        .o_load     (load),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_sample   (o_sample_out),
        .o_last     (o_last)
    );

endmodule

`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import au2x_pkg::*;

    localparam int SMP_W          = 24;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_PHASES    = 6;
    localparam int PHASE_ITEMS    = 150;
    localparam int LONG_HOLD      = 80;
    localparam int DIR_LEN        = 28;

    localparam logic [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam logic [SMP_W-1:0] SMP_ZERO = '0;

    // midpoint filter weights, sum over 2**FIR_SHIFT
    localparam longint FIR_OUTER  = 3;
    localparam longint FIR_INNER  = 25;
    localparam longint FIR_CENTER = 150;
    localparam int     FIR_SHIFT  = 8;
    localparam longint FIR_BIAS   = 128;
    localparam longint CLAMP_HI   = (64'sd1 <<< (SMP_W - 1)) - 1;
    localparam longint CLAMP_LO   = -(64'sd1 <<< (SMP_W - 1));

    typedef enum logic {ROW_SAMPLE, ROW_SET_MODE} t_row_kind;

    typedef struct packed {
        t_row_kind        kind;
        logic [SMP_W-1:0] value;
        logic             typed;
        logic [SMP_W-1:0] exp_first;
        logic [SMP_W-1:0] exp_second;
    } t_dir_row;

    typedef struct packed {
        logic [SMP_W-1:0] smp;
        logic             last;
    } t_beat;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic             cfg_wdata = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [SMP_W-1:0] sample_in = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [SMP_W-1:0] sample_out;
    logic             out_last;

    // predictor state
    logic             mode_q = MODE_RESET;
    longint           hist [0:4] = '{0, 0, 0, 0, 0};

    t_beat            pending_beats [$];
    t_beat            want;
    int               errors = 0;
    int               beats_out = 0;
    int               idle_cycles = 0;
    bit               long_hold_done = 0;
    bit               burst = 0;

    // Saturation rows: six-sample windows of full-scale values, centre pair of one sign, inner pair of the other.
    // Linear rows: means across the full range, then rounding near zero.
    t_dir_row dir_rows [0:DIR_LEN-1] = '{
        '{ROW_SAMPLE,   SMP_ZERO,           1'b1, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MIN,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MIN,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b1, SMP_MAX,  SMP_MAX},
        '{ROW_SAMPLE,   SMP_MIN,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MIN,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MIN,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MIN,            1'b1, SMP_MIN,  SMP_MIN},
        '{ROW_SET_MODE, SMP_W'(MODE_LINEAR), 1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_MAX,            1'b1, SMP_ZERO, SMP_MAX},
        '{ROW_SAMPLE,   SMP_MAX,            1'b1, SMP_MAX,  SMP_MAX},
        '{ROW_SAMPLE,   SMP_MIN,            1'b1, SMP_ZERO, SMP_MIN},
        '{ROW_SAMPLE,   SMP_MIN,            1'b1, SMP_MIN,  SMP_MIN},
        '{ROW_SAMPLE,   24'h000001,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'hFFFFFF,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'h000002,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'hFFFFFE,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SET_MODE, SMP_W'(MODE_LAGRANGE), 1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'h000005,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'hFFFFF9,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'h555555,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   24'hAAAAAA,         1'b0, SMP_ZERO, SMP_ZERO},
        '{ROW_SAMPLE,   SMP_ZERO,           1'b0, SMP_ZERO, SMP_ZERO}
    };

    audio_2x_upsampler_unit #(
        .SAMPLE_BITS(SMP_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_sample_in (sample_in),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_sample_out(sample_out),
        .o_last      (out_last)
    );

    always #1 clk = ~clk;

    // Both results for one sample; history shifts in every mode.
    task automatic predict_pair(input logic [SMP_W-1:0] raw,
                                output logic [SMP_W-1:0] first,
                                output logic [SMP_W-1:0] second);
        longint x;
        longint acc;
        longint y;
        x = longint'($signed(raw));
        if (mode_q == MODE_LINEAR) begin
            y = (hist[4] + x + 1) >>> 1;
            second = raw;
        end else begin
            acc = FIR_OUTER * (hist[0] + x) - FIR_INNER * (hist[1] + hist[4])
                + FIR_CENTER * (hist[2] + hist[3]);
            y = (acc + FIR_BIAS) >>> FIR_SHIFT;
            if (y > CLAMP_HI) y = CLAMP_HI;
            if (y < CLAMP_LO) y = CLAMP_LO;
            second = hist[3][SMP_W-1:0];
        end
        first = y[SMP_W-1:0];
        for (int i = 0; i < 4; i++) hist[i] = hist[i + 1];
        hist[4] = x;
    endtask

    task automatic send_beat(input logic [SMP_W-1:0] smp, input logic typed,
                             input logic [SMP_W-1:0] t_first,
                             input logic [SMP_W-1:0] t_second);
        logic [SMP_W-1:0] p_first;
        logic [SMP_W-1:0] p_second;
        int gap;
        int r;
        in_valid  <= 1'b1;
        sample_in <= smp;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_pair(smp, p_first, p_second);
        if (typed) begin
            p_first  = t_first;
            p_second = t_second;
        end
        pending_beats.push_back('{p_first, 1'b0});
        pending_beats.push_back('{p_second, 1'b1});
        r = $urandom_range(0, 99);
        if (burst || r < 55) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 40);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // mode may only change with the pipe empty
    task automatic drain_and_set_mode(input logic m);
        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        mode_q = m;
    endtask

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            beats_out++;
            if (pending_beats.size() == 0) begin
                $display("%0t: unexpected beat, sample_out %h last %b",
                         $time, sample_out, out_last);
                errors++;
            end else begin
                want = pending_beats.pop_front();
                if (want.smp !== sample_out) begin
                    $display("%0t: sample_out mismatch, expected %h actual %h",
                             $time, want.smp, sample_out);
                    errors++;
                end
                if (want.last !== out_last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, out_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stalls, one long hold-off to back up the input
    initial begin
        int r;
        int len;
        logic val;
        forever begin
            if (!long_hold_done && beats_out >= 600) begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold_done = 1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    val = 1'b0;
                    len = $urandom_range(1, 4);
                end else if (r < 80) begin
                    val = 1'b1;
                    len = $urandom_range(1, 2);
                end else if (r < 92) begin
                    val = 1'b0;
                    len = $urandom_range(20, 60);
                end else if (r < 98) begin
                    val = 1'b1;
                    len = $urandom_range(3, 10);
                end else begin
                    val = 1'b1;
                    len = $urandom_range(15, 30);
                end
                out_stall <= val;
                repeat (len) @(posedge clk);
            end
        end
    end

    initial begin
        logic [SMP_W-1:0] s;
        int r;
        int sat_left;
        sat_left = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_LEN; i++) begin
            if (dir_rows[i].kind == ROW_SET_MODE) begin
                drain_and_set_mode(dir_rows[i].value[0]);
            end else begin
                send_beat(dir_rows[i].value, dir_rows[i].typed,
                          dir_rows[i].exp_first, dir_rows[i].exp_second);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            if (ph == 0) drain_and_set_mode(MODE_LINEAR);
            else if (ph == 1) drain_and_set_mode(MODE_LAGRANGE);
            else drain_and_set_mode(1'($urandom_range(0, 1)));
            burst = (ph == 2) || ($urandom_range(0, 4) == 0);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (sat_left > 0) begin
                    // pairs of full-scale values of one sign drive the filter into clamp
                    if (((sat_left >> 1) & 1) != 0) s = SMP_MIN + SMP_W'($urandom_range(0, 255));
                    else s = SMP_MAX - SMP_W'($urandom_range(0, 255));
                    sat_left--;
                end else begin
                    r = $urandom_range(0, 9);
                    case (r)
                        0: s = SMP_MAX;
                        1: s = SMP_MIN;
                        2: s = SMP_W'($urandom_range(0, 32)) - SMP_W'(16);
                        3: begin
                            s = SMP_MAX;
                            sat_left = 8;
                        end
                        default: s = SMP_W'($urandom);
                    endcase
                end
                send_beat(s, 1'b0, SMP_ZERO, SMP_ZERO);
            end
        end

        in_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (errors == 0 && pending_beats.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* sim.f */
src/au2x_pkg.sv
src/au2x_window.sv
src/au2x_interp.sv
src/au2x_out.sv
src/audio_2x_upsampler_unit.sv
tb/testbench.sv
